// ===== rtl/bfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants of the Bloom filter engine: hash constants,
// register indexes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package bfe_pkg;

    // FNV-1a offset as kept by the original code, and its 64-bit prime.
    // The prime is 2^40 + 435, which the datapath uses as shifts and adds.
    localparam logic [63:0] FNV_OFFSET = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
    localparam logic [7:0]  MUL_FACTOR = 8'd131;

    // Register indexes on the configuration port.
    localparam logic REG_FILTER_BITS = 1'b0;
    localparam logic REG_PROBE_COUNT = 1'b1;

    // Reset values of the registers.
    localparam logic [16:0] FILTER_BITS_RESET = 17'd65536;
    localparam logic [5:0]  PROBE_COUNT_RESET = 6'd7;

    // Limits of the effective settings.
    localparam int unsigned MIN_BITS   = 64;
    localparam logic [5:0]  MAX_PROBES = 6'd32;

    // Key kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Index of the top dividend bit in the remainder sweep (65 bits).
    localparam logic [6:0] BIT_TOP = 7'd64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear_wr;      // write a zero at the clearing address
        logic mod_step;      // one step of the remainder sweep
        logic probe_access;  // access the store at the current position
        logic probe_advance; // move to the next probe position
        logic miss;          // a queried bit was found clear
        logic emit;          // load the result into the output register
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic mod_done;
        logic probe_last;
        logic kind_query;
        logic rd_bit;
        logic out_free;
    } sts_t;

endpackage : bfe_pkg
`default_nettype wire

// ===== rtl/bloom_filter_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_engine
// Bloom filter with double hashing over keys streamed one byte per transfer.
// ----------------------------------------------------------------------------
// Usage. Each input transfer carries at most one key byte (has_byte) and the
// last transfer of a key carries last and the key kind (insert or query).
// Byte transfers are taken one per cycle while the block is idle. On a last
// transfer the block stalls its input while it reduces both hashes modulo the
// filter size in a remainder sweep, then walks the probes through the bit
// store: an insert writes each probe's bit in ST_PROBE, while a query reads
// each probe in ST_PROBE and tests the registered read in ST_CHECK, a query
// stopping at the first clear bit. Exactly one result transfer follows each
// key: was_query echoes the kind and maybe_present reports the query outcome
// (always 1 for an insert). The result sits in an output register, so key
// bytes keep flowing while it waits; a further key end holds in its final
// state until the register is taken. After reset the store is swept clear at
// one bit per cycle over all MAX_BITS bits, with the input stalled;
// configuration writes are taken throughout. Registers: filter_bits at byte
// address 0 and probe_count at address 4.
// ----------------------------------------------------------------------------
module bloom_filter_engine #(
    parameter int MAX_BITS = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // key channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic        has_byte,
    input  wire logic [7:0]  key_byte,
    input  wire logic        last,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             was_query,
    output logic             maybe_present,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bfe_pkg::*;

    logic [16:0] filter_bits_reg;
    logic [5:0]  probe_count_reg;
    logic        cfg_write;
    logic        in_accept;
    cmd_t        cmd;
    sts_t        sts;

    // The register index is taken from the word address; the low byte-lane
    // bits are not decoded.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= FILTER_BITS_RESET;
            probe_count_reg <= PROBE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_FILTER_BITS)
            begin
                filter_bits_reg <= pwdata[16:0];
            end
            else
            begin
                probe_count_reg <= pwdata[5:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PROBE_COUNT)
        begin
            prdata = {26'd0, probe_count_reg};
        end
        else
        begin
            prdata = {15'd0, filter_bits_reg};
        end
    end

    // A transfer is taken whenever valid meets an unstalled input.
    assign in_accept = in_valid && !in_stall;

    bfe_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_last (last),
        .sts     (sts),
        .cmd     (cmd),
        .in_stall(in_stall)
    );

    bfe_datapath #(
        .MAX_BITS(MAX_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .kind         (kind),
        .has_byte     (has_byte),
        .key_byte     (key_byte),
        .last         (last),
        .filter_bits  (filter_bits_reg),
        .probe_count  (probe_count_reg),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .was_query    (was_query),
        .maybe_present(maybe_present)
    );

`ifndef ASSERT_OFF
    // A result is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || !out_stall))
        else $error("result loaded over a waiting result");

    // Taking the end of a key makes the block busy in the next cycle.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last) |=> in_stall)
        else $error("input not stalled after a key end");

    // The last remainder step is followed by the first probe access.
    a_sweep_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mod_step && sts.mod_done) |=> cmd.probe_access)
        else $error("probe loop did not follow the remainder sweep");
`endif

endmodule : bloom_filter_engine
`default_nettype wire

// ===== rtl/bfe_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module bfe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule : bfe_ram
`default_nettype wire

// ===== rtl/bfe_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_ctrl
// Sequencer of the engine: clearing pass, key intake, remainder sweep,
// probe loop and result hand-over.
// ----------------------------------------------------------------------------
module bfe_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_last,
    input  wire bfe_pkg::sts_t sts,
    output bfe_pkg::cmd_t      cmd,
    output logic               in_stall
);
    import bfe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (sts.kind_query)
                begin
                    state_next = ST_CHECK;
                end
                else if (sts.probe_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CHECK:
            begin
                if (!sts.rd_bit || sts.probe_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            ST_PROBE:
            begin
                cmd.probe_access  = 1'b1;
                cmd.probe_advance = !sts.kind_query && !sts.probe_last;
            end
            ST_CHECK:
            begin
                cmd.miss          = !sts.rd_bit;
                cmd.probe_advance = sts.rd_bit && !sts.probe_last;
            end
            ST_FINISH:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule : bfe_ctrl
`default_nettype wire

// ===== rtl/bfe_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_datapath
// Running hashes, remainder sweep, probe position stepping, bit store and
// result register.
// ----------------------------------------------------------------------------
module bfe_datapath #(
    parameter int MAX_BITS = 65536
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_accept,
    input  wire logic          kind,
    input  wire logic          has_byte,
    input  wire logic [7:0]    key_byte,
    input  wire logic          last,
    input  wire logic [16:0]   filter_bits,
    input  wire logic [5:0]    probe_count,
    input  wire logic          out_stall,
    input  wire bfe_pkg::cmd_t cmd,
    output bfe_pkg::sts_t      sts,
    output logic               out_valid,
    output logic               was_query,
    output logic               maybe_present
);
    import bfe_pkg::*;

    localparam int AW = $clog2(MAX_BITS);
    localparam int NW = $clog2(MAX_BITS + 1);

    // Running hashes.
    logic [63:0] fnv_reg;
    logic [63:0] mul_reg;
    logic [63:0] fnv_x;
    logic [63:0] fnv_upd;
    logic [63:0] mul_upd;

    // Key-end working registers.
    logic [63:0]   acc_reg;
    logic [63:0]   step_reg;
    logic [NW-1:0] pos_reg;
    logic [NW-1:0] rstep_reg;
    logic [NW-1:0] wrap_reg;
    logic [6:0]    bit_reg;
    logic [4:0]    idx_reg;
    logic          kind_reg;
    logic          present_reg;
    logic [AW-1:0] clr_reg;

    logic [NW-1:0] nb;
    logic [31:0]   fb32;
    logic [5:0]    k_eff;
    logic          bit_acc;
    logic          bit_step;
    logic          bit_wrap;
    logic [64:0]   acc_sum;
    logic [NW-1:0] pos_next;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic          mem_rdata;

    function automatic logic [NW-1:0] rem_step(input logic [NW-1:0] r, input logic b,
                                                 input logic [NW-1:0] n);
        logic [NW:0] t;
        t = {r, b};
        if (t >= {1'b0, n})
        begin
            t = t - {1'b0, n};
        end
        return t[NW-1:0];
    endfunction

    // FNV prime is 2^40 + 435 (435 = 256 + 128 + 32 + 16 + 2 + 1).
    assign fnv_x   = fnv_reg ^ {56'd0, key_byte};
    assign fnv_upd = (fnv_x << 40) + (fnv_x << 8) + (fnv_x << 7) + (fnv_x << 5)
                   + (fnv_x << 4) + (fnv_x << 1) + fnv_x;
    assign mul_upd = (mul_reg << 7) + (mul_reg << 1) + mul_reg + {56'd0, key_byte};

    // Effective modulus and probe count, saturated to their ranges.
    always_comb
    begin
        fb32 = {15'd0, filter_bits};
        if (fb32 < 32'(MIN_BITS))
        begin
            fb32 = 32'(MIN_BITS);
        end
        else if (fb32 > 32'(MAX_BITS))
        begin
            fb32 = 32'(MAX_BITS);
        end
        nb = fb32[NW-1:0];

        if (probe_count == 6'd0)
        begin
            k_eff = 6'd1;
        end
        else if (probe_count > MAX_PROBES)
        begin
            k_eff = MAX_PROBES;
        end
        else
        begin
            k_eff = probe_count;
        end
    end

    // Dividend bits of the sweep: the two hashes and 2^64.
    assign bit_acc  = (bit_reg == BIT_TOP) ? 1'b0 : acc_reg[bit_reg[5:0]];
    assign bit_step = (bit_reg == BIT_TOP) ? 1'b0 : step_reg[bit_reg[5:0]];
    assign bit_wrap = (bit_reg == BIT_TOP);

    // Next probe position: add the step residue, and take off 2^64 mod n
    // whenever the 64-bit sum wraps.
    assign acc_sum = {1'b0, acc_reg} + {1'b0, step_reg};

    always_comb
    begin
        logic [NW:0] t;
        logic [NW:0] t1;
        logic [NW:0] t2;
        t  = {1'b0, pos_reg} + {1'b0, rstep_reg};
        t1 = (t >= {1'b0, nb}) ? (t - {1'b0, nb}) : t;
        if (!acc_sum[64])
        begin
            t2 = t1;
        end
        else if (t1 >= {1'b0, wrap_reg})
        begin
            t2 = t1 - {1'b0, wrap_reg};
        end
        else
        begin
            t2 = t1 + {1'b0, nb} - {1'b0, wrap_reg};
        end
        pos_next = t2[NW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fnv_reg   <= FNV_OFFSET;
            mul_reg   <= 64'd0;
            clr_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (in_accept && last)
            begin
                fnv_reg <= FNV_OFFSET;
                mul_reg <= 64'd0;
            end
            else if (in_accept && has_byte)
            begin
                fnv_reg <= fnv_upd;
                mul_reg <= mul_upd;
            end
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && last)
        begin
            acc_reg     <= has_byte ? fnv_upd : fnv_reg;
            step_reg    <= has_byte ? mul_upd : mul_reg;
            kind_reg    <= kind;
            present_reg <= 1'b1;
            pos_reg     <= '0;
            rstep_reg   <= '0;
            wrap_reg    <= '0;
            bit_reg     <= BIT_TOP;
            idx_reg     <= 5'd0;
        end
        else if (cmd.mod_step)
        begin
            pos_reg   <= rem_step(pos_reg, bit_acc, nb);
            rstep_reg <= rem_step(rstep_reg, bit_step, nb);
            wrap_reg  <= rem_step(wrap_reg, bit_wrap, nb);
            bit_reg   <= bit_reg - 7'd1;
        end
        else if (cmd.probe_advance)
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_sum[63:0];
            idx_reg <= idx_reg + 5'd1;
        end
        if (cmd.miss)
        begin
            present_reg <= 1'b0;
        end
        if (cmd.emit)
        begin
            was_query     <= kind_reg;
            maybe_present <= present_reg && !cmd.miss;
        end
    end

    assign mem_we   = cmd.clear_wr || (cmd.probe_access && (kind_reg == KIND_INSERT));
    assign mem_addr = cmd.clear_wr ? clr_reg : pos_reg[AW-1:0];

    bfe_ram #(
        .WIDTH(1),
        .DEPTH(MAX_BITS)
    ) u_store (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(!cmd.clear_wr),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        sts.clear_done = (clr_reg == AW'(MAX_BITS - 1));
        sts.mod_done   = (bit_reg == 7'd0);
        sts.probe_last = (({1'b0, idx_reg} + 6'd1) == k_eff);
        sts.kind_query = (kind_reg == KIND_QUERY);
        sts.rd_bit     = mem_rdata;
        sts.out_free   = !out_valid || !out_stall;
    end

endmodule : bfe_datapath
`default_nettype wire

// ===== tb/bloom_filter_engine_test.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_engine_test
// Self-checking bench for the Bloom filter engine. Keys are streamed at most
// a byte per transfer and every key end is predicted by a local double-hashing
// model with its own bit store, then compared with the result transfers in order.
// ----------------------------------------------------------------------------
module bloom_filter_engine_test;
    import bfe_pkg::*;

    localparam int STORE_BITS = 65536;
    // Watchdog limit for a stretch without any transfer; it must exceed the
    // clearing pass that follows reset.
    localparam int HANG_LIMIT = 200000;
    localparam logic [63:0] HASH_SEED  = 64'd1469598103934665603;
    localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

    // The scoreboard keeps the predicted results and counts mismatches.
    class filter_scoreboard;
        bit pending_kind[$];
        bit pending_hit[$];
        int errors;
        int checked;

        function void note_key_end(bit k, bit hit);
            pending_kind = {pending_kind, k};
            pending_hit  = {pending_hit, hit};
        endfunction

        task check_result(bit k, bit hit);
            bit ek;
            bit eh;
            if (pending_kind.size() == 0)
            begin
                report_mismatch("result transfer with nothing expected");
                return;
            end
            ek = pending_kind.pop_front();
            eh = pending_hit.pop_front();
            checked++;
            if (k !== ek)
                report_mismatch($sformatf("was_query %0b, expected %0b", k, ek));
            if (hit !== eh)
                report_mismatch($sformatf("maybe_present %0b, expected %0b", hit, eh));
        endtask

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic        has_byte = 1'b0;
    logic [7:0]  key_byte = 8'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        was_query;
    logic        maybe_present;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    bloom_filter_engine u_dut (.*);

    always #2 clk = ~clk;

    // Predictor state: the two running hashes, the settings and the filter.
    filter_scoreboard sb;
    logic [63:0] fnv_acc;
    logic [63:0] mul_acc;
    logic [16:0] bits_reg;
    logic [5:0]  probes_reg;
    bit          filter_map [STORE_BITS];

    int  idle_cycles;
    int  keys_sent;
    int  queries_sent;
    bit  timed_out;

    // Apply one key transfer to the predictor; a key end yields a result.
    task automatic absorb_transfer(bit k, bit hb, logic [7:0] b, bit lst);
        logic [63:0] nb;
        logic [63:0] np;
        logic [63:0] pos;
        bit hit;
        hit = 1'b1;
        if (hb)
        begin
            fnv_acc = (fnv_acc ^ {56'd0, b}) * HASH_PRIME;
            mul_acc = mul_acc * 64'd131 + {56'd0, b};
        end
        if (!lst)
            return;
        nb = bits_reg;
        if (nb < 64) nb = 64;
        if (nb > STORE_BITS) nb = STORE_BITS;
        np = probes_reg;
        if (np < 1) np = 1;
        if (np > 32) np = 32;
        for (int i = 0; i < np; i++)
        begin
            pos = (fnv_acc + 64'(i) * mul_acc) % nb;
            if (k == KIND_INSERT)
                filter_map[pos] = 1'b1;
            else if (!filter_map[pos])
            begin
                hit = 1'b0;
                break;
            end
        end
        sb.note_key_end(k, hit);
        fnv_acc = HASH_SEED;
        mul_acc = 64'd0;
        keys_sent++;
        if (k == KIND_QUERY) queries_sent++;
    endtask

    // Offer one transfer and hold it until the block takes it.
    task automatic send_transfer(bit k, bit hb, logic [7:0] b, bit lst);
        in_valid <= 1'b1;
        kind     <= k;
        has_byte <= hb;
        key_byte <= b;
        last     <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_transfer(k, hb, b, lst);
    endtask

    // Drop valid between bursts for a random gap.
    task automatic idle_gap(int n);
        if (n == 0)
            return;
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_key(bit k, int len, bit empty_tail);
        for (int i = 0; i < len; i++)
            send_transfer(k, 1'b1, 8'($urandom), (i == len - 1) && !empty_tail);
        if (empty_tail || len == 0)
            send_transfer(k, 1'b0, 8'($urandom), 1'b1);
    endtask

    // Wait until every predicted result has arrived, then let the block settle.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_kind.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_FILTER_BITS) bits_reg = value[16:0];
        else probes_reg = value[5:0];
    endtask

    // Checks result transfers and stalls the result side on its own pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(was_query, maybe_present);
            case ($urandom_range(0, 3))
                0:       out_stall <= 1'b1;
                default: out_stall <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("bloom_filter_engine_test: errors");
            $finish;
        end
    end

    // Random traffic: keys of random length, some ending in a byte-less transfer.
    task automatic random_phase(int n_keys, bit reuse);
        logic [7:0] saved [$];
        for (int j = 0; j < n_keys; j++)
        begin
            bit k;
            int len;
            k = $urandom_range(0, 1);
            len = $urandom_range(0, 6);
            if (reuse && k == KIND_QUERY && saved.size() != 0 && $urandom_range(0, 1))
            begin
                // Query a key inserted earlier, so hits are exercised too.
                foreach (saved[i])
                    send_transfer(k, 1'b1, saved[i], i == saved.size() - 1);
            end
            else
            begin
                if (k == KIND_INSERT) saved.delete();
                for (int i = 0; i <= len; i++)
                begin
                    bit hb;
                    logic [7:0] b;
                    hb = (i < len) || ($urandom_range(0, 3) != 0);
                    b = 8'($urandom);
                    if (hb && k == KIND_INSERT) saved = {saved, b};
                    send_transfer(k, hb, b, i == len);
                    if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 4));
                end
            end
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(0, 8));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        sb = new();
        fnv_acc = HASH_SEED;
        mul_acc = 64'd0;
        bits_reg = 17'd65536;
        probes_reg = 6'd7;
        idle_cycles = 0;
        keys_sent = 0;
        queries_sent = 0;
        timed_out = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: empty keys, extreme bytes, hits.
        send_transfer(KIND_QUERY, 1'b0, 8'hff, 1'b1);
        send_transfer(KIND_INSERT, 1'b0, 8'h00, 1'b1);
        send_transfer(KIND_QUERY, 1'b0, 8'h5a, 1'b1);
        send_transfer(KIND_INSERT, 1'b1, 8'hff, 1'b0);
        send_transfer(KIND_INSERT, 1'b1, 8'h00, 1'b1);
        send_transfer(KIND_QUERY, 1'b1, 8'hff, 1'b0);
        send_transfer(KIND_QUERY, 1'b1, 8'h00, 1'b1);
        send_transfer(KIND_QUERY, 1'b1, 8'h55, 1'b0);
        send_transfer(KIND_QUERY, 1'b1, 8'haa, 1'b1);
        drain();

        // Settings at the extremes, including saturated values and a write
        // at an address inside the first register's word.
        write_register(3'd0, 32'd64);
        write_register(3'd4, 32'd32);
        write_register(3'd0 + 3'd2, 32'hffff_ffff);
        send_key(KIND_INSERT, 3, 1'b0);
        send_key(KIND_QUERY, 0, 1'b1);
        send_key(KIND_QUERY, 2, 1'b1);
        drain();
        write_register(3'd0, 32'd0);
        write_register(3'd4, 32'd0);
        random_phase(10, 1'b1);
        drain();
        write_register(3'd0, 32'h1ffff);
        write_register(3'd4, 32'h3f);
        random_phase(10, 1'b1);
        drain();
        write_register(3'd0, 32'd65535);
        write_register(3'd4, 32'd1);
        random_phase(20, 1'b1);
        drain();

        // Bulk random traffic over a few mid-range settings.
        for (int phase = 0; phase < 4 && !timed_out; phase++)
        begin
            write_register(3'd0, $urandom_range(64, 4096));
            write_register(3'd4, $urandom_range(1, 12));
            random_phase(15, 1'b1);
            drain();
        end

        $display("covered %0d keys (%0d queries), %0d results checked",
                 keys_sent, queries_sent, sb.checked);
        $display("settings ran from the smallest filter and one probe up to saturated values");
        if (sb.errors == 0 && sb.pending_kind.size() == 0)
            $display("bloom_filter_engine_test: clean");
        else
            $display("bloom_filter_engine_test: errors");
        $finish;
    end
endmodule

// ===== bloom_filter_engine.f =====
rtl/bfe_pkg.sv
rtl/bfe_ram.sv
rtl/bfe_ctrl.sv
rtl/bfe_datapath.sv
rtl/bloom_filter_engine.sv
tb/bloom_filter_engine_test.sv
